/* hw/rtl/md5_pkg.sv */
// ============================================================================
// MD5 stream hasher package
// Shared constants, types and round tables for the MD5 controller and datapath.
// ============================================================================
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [31:0] PAD_BYTE = 32'h00000080;

    // Block store write source selection.
    typedef enum logic [1:0] {
        WSEL_DATA = 2'd0,
        WSEL_PAD  = 2'd1,
        WSEL_ZERO = 2'd2,
        WSEL_LEN  = 2'd3
    } wsel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       store_wr;
        logic [3:0] store_addr;
        wsel_t      store_sel;
        logic       len_hi;
        logic       cnt_add;
        logic       round_start;
        logic       round_step;
        logic       round_done;
        logic       chain_init;
    } md5_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [3:0] word_idx;
        logic [5:0] round_idx;
    } md5_stat_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
                6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
                6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
                6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
                6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
                6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
                6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
                6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
                6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
                6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
                6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
                default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
                4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
                4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    // Message word index used by a round.
    function automatic logic [3:0] round_g(input logic [5:0] i);
        logic [3:0] g;
        begin
            case (i[5:4])
                2'd0: g = i[3:0];
                2'd1: g = 4'((5 * i[3:0]) + 1);
                2'd2: g = 4'((3 * i[3:0]) + 5);
                default: g = 4'(7 * i[3:0]);
            endcase
            return g;
        end
    endfunction

endpackage

/* hw/rtl/md5_if.sv */
// ============================================================================
// MD5 stream interfaces
// Valid/ready channels for message input and digest output.
// ============================================================================
interface md5_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_of_message;
    modport source (output valid, data_word, byte_count, last_of_message, input ready);
    modport sink (input valid, data_word, byte_count, last_of_message, output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* hw/rtl/md5_datapath.sv */
// ============================================================================
// MD5 datapath
// Block store, byte counter, chaining words and the one-round-per-cycle unit.
// ============================================================================
module md5_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  md5_pkg::md5_cmd_t   cmd,
    output md5_pkg::md5_stat_t  stat,
    input  logic [31:0]         data_word,
    input  logic [2:0]          byte_count,
    input  logic                last_of_message,
    input  logic [1:0]          out_sel,
    output logic [31:0]         chain_word
);

    logic [31:0] store_mem [16];
    logic [60:0] bytes_reg, bytes_next;
    logic [5:0]  round_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic [31:0] mword_reg;
    logic [2:0]  cnt;
    logic [31:0] masked;
    logic [31:0] wdata;
    logic [63:0] bits;
    logic [31:0] f, t, rot;
    logic [5:0]  rnext;

    // Effective byte count of this item, saturated to four.
    assign cnt = (!last_of_message || byte_count > 3'd4) ? 3'd4 : byte_count;

    // Keep the valid bytes and, when fewer than four are valid, place the pad byte just after them.
    always_comb
    begin
        case (cnt)
            3'd0: masked = md5_pkg::PAD_BYTE;
            3'd1: masked = {16'h0, 8'h80, data_word[7:0]};
            3'd2: masked = {8'h0, 8'h80, data_word[15:0]};
            3'd3: masked = {8'h80, data_word[23:0]};
            default: masked = data_word;
        endcase
    end

    assign bits = {bytes_reg, 3'b000};

    always_comb
    begin
        case (cmd.store_sel)
            md5_pkg::WSEL_DATA: wdata = masked;
            md5_pkg::WSEL_PAD:  wdata = md5_pkg::PAD_BYTE;
            md5_pkg::WSEL_ZERO: wdata = 32'h0;
            default:            wdata = cmd.len_hi ? bits[63:32] : bits[31:0];
        endcase
    end

    assign bytes_next = bytes_reg + 61'(cnt);

    // Byte counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bytes_reg <= '0;
        else if (cmd.chain_init)
            bytes_reg <= '0;
        else if (cmd.cnt_add)
            bytes_reg <= bytes_next;
    end

    // Round index for the next cycle; the operand is fetched one round ahead.
    assign rnext = cmd.round_start ? 6'd0 : 6'(round_reg + 6'd1);

    // Block store with registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
            store_mem[cmd.store_addr] <= wdata;
        mword_reg <= store_mem[md5_pkg::round_g(rnext)];
    end

    // One MD5 round.
    always_comb
    begin
        case (round_reg[5:4])
            2'd0: f = d_reg ^ (b_reg & (c_reg ^ d_reg));
            2'd1: f = c_reg ^ (d_reg & (b_reg ^ c_reg));
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        t = a_reg + f + mword_reg + md5_pkg::round_k(round_reg);
        rot = (t << md5_pkg::round_s(round_reg)) |
              (t >> (6'd32 - {1'b0, md5_pkg::round_s(round_reg)}));
    end

    // Round registers; load happens in the cycle before round zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            round_reg <= '0;
        else if (cmd.round_start || cmd.round_step)
            round_reg <= rnext;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.round_start)
        begin
            a_reg <= ca_reg; b_reg <= cb_reg; c_reg <= cc_reg; d_reg <= cd_reg;
        end
        else if (cmd.round_step)
        begin
            a_reg <= d_reg; d_reg <= c_reg; c_reg <= b_reg; b_reg <= b_reg + rot;
        end
    end

    // Chaining words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg <= md5_pkg::INIT_A; cb_reg <= md5_pkg::INIT_B;
            cc_reg <= md5_pkg::INIT_C; cd_reg <= md5_pkg::INIT_D;
        end
        else if (cmd.chain_init)
        begin
            ca_reg <= md5_pkg::INIT_A; cb_reg <= md5_pkg::INIT_B;
            cc_reg <= md5_pkg::INIT_C; cd_reg <= md5_pkg::INIT_D;
        end
        else if (cmd.round_done)
        begin
            ca_reg <= ca_reg + a_reg; cb_reg <= cb_reg + b_reg;
            cc_reg <= cc_reg + c_reg; cd_reg <= cd_reg + d_reg;
        end
    end

    always_comb
    begin
        case (out_sel)
            2'd0: chain_word = ca_reg;
            2'd1: chain_word = cb_reg;
            2'd2: chain_word = cc_reg;
            default: chain_word = cd_reg;
        endcase
    end

    assign stat.word_idx = bytes_reg[5:2];
    assign stat.round_idx = round_reg;

endmodule

/* hw/rtl/md5_ctrl.sv */
// ============================================================================
// MD5 controller
// Sequences word intake, padding, the 64 rounds and digest output.
// ============================================================================
module md5_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         byte_count,
    input  logic               last_of_message,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_sel,
    output md5_pkg::md5_cmd_t  cmd,
    input  md5_pkg::md5_stat_t stat
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_LOAD  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  ptr_reg, ptr_next;      // next store slot during padding
    logic        padded_reg, padded_next; // pad byte already placed
    logic        final_reg, final_next;  // the running block is the last
    logic        msg_reg, msg_next;      // last item of the message taken
    logic [1:0]  osel_reg, osel_next;
    logic        take;

    assign in_ready = (state_reg == ST_IDLE);
    assign take = in_valid && in_ready;
    assign out_valid = (state_reg == ST_OUT);
    assign out_sel = osel_reg;

    // Next-state and command logic.
    always_comb
    begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        padded_next = padded_reg;
        final_next = final_reg;
        osel_next = osel_reg;
        cmd = '0;
        cmd.store_sel = md5_pkg::WSEL_DATA;
        cmd.store_addr = ptr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.store_addr = stat.word_idx;
                if (take)
                begin
                    cmd.store_wr = 1'b1;
                    cmd.cnt_add = 1'b1;
                    ptr_next = 4'(stat.word_idx + 4'd1);
                    // A short last word below slot 14 leaves room for the length.
                    final_next = last_of_message && (byte_count < 3'd4) &&
                                 (stat.word_idx <= 4'd13);
                    padded_next = !(last_of_message && byte_count >= 3'd4);
                    if (!last_of_message)
                    begin
                        if (stat.word_idx == 4'd15)
                            state_next = ST_LOAD;
                    end
                    else if (stat.word_idx == 4'd15)
                        state_next = ST_LOAD;
                    else
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                cmd.store_wr = 1'b1;
                ptr_next = 4'(ptr_reg + 4'd1);
                if (!padded_reg)
                begin
                    cmd.store_sel = md5_pkg::WSEL_PAD;
                    padded_next = 1'b1;
                end
                else if (ptr_reg >= 4'd14 && (ptr_reg != 4'd15 || !final_reg) &&
                         ptr_reg == 4'd14 && final_reg)
                    cmd.store_sel = md5_pkg::WSEL_LEN;
                else
                    cmd.store_sel = md5_pkg::WSEL_ZERO;
                // Length words go into slots 14 and 15 once the pad fits.
                if (padded_reg && final_reg && ptr_reg >= 4'd14)
                begin
                    cmd.store_sel = md5_pkg::WSEL_LEN;
                    cmd.len_hi = ptr_reg[0];
                end
                if (ptr_reg == 4'd15)
                    state_next = ST_LOAD;
                else if (!padded_reg && ptr_reg == 4'd14)
                    final_next = 1'b0;
                // Decide whether this block can hold the length.
                if (ptr_reg == 4'd13 || (!padded_reg && ptr_reg <= 4'd13))
                    final_next = 1'b1;
                if (ptr_reg == 4'd15 && !final_reg)
                    final_next = 1'b0;
            end
            ST_LOAD:
            begin
                cmd.round_start = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (stat.round_idx == 6'd63)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.round_done = 1'b1;
                if (final_reg)
                begin
                    state_next = ST_OUT;
                    osel_next = 2'd0;
                end
                else if (padded_reg && ptr_reg == 4'd0 && !msg_reg)
                    state_next = ST_IDLE;
                else
                begin
                    // Last message block still needs padding or length.
                    state_next = ST_PAD;
                    final_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    osel_next = 2'(osel_reg + 2'd1);
                    if (osel_reg == 2'd3)
                    begin
                        cmd.chain_init = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // A message is in progress past its last item.
    always_comb
    begin
        msg_next = msg_reg;
        if (take)
            msg_next = last_of_message;
        else if (state_reg == ST_OUT && out_ready && osel_reg == 2'd3)
            msg_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg <= '0;
            padded_reg <= 1'b0;
            final_reg <= 1'b0;
            osel_reg <= '0;
            msg_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg <= ptr_next;
            padded_reg <= padded_next;
            final_reg <= final_next;
            osel_reg <= osel_next;
            msg_reg <= msg_next;
        end
    end

`ifndef SYNTHESIS
    a_out_after_add: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_OUT) |-> $past(state_reg == ST_ADD))
        else $error("digest output without a finished block");
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> (stat.round_idx == 6'd0 || stat.round_idx == 6'd63))
        else $error("round counter out of step");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input accepted while busy");
`endif

endmodule

/* hw/rtl/md5_stream_hasher.sv */
// ============================================================================
// MD5 stream hasher
// Byte-stream MD5 digest engine with message padding and digest output.
// ============================================================================
// Takes a message as 32-bit little-endian words, four bytes per transaction
// except on the last, and emits the four digest words a, b, c, d after it.
// The sixteenth word of a block starts compression: a load, the 64 rounds
// (one round per cycle from the registered-read block store) and the
// chaining add. The last word adds padding writes and one or two
// compressions, then four output transactions. No new input is taken
// until the digest is out.
module md5_stream_hasher (
    input logic clk,
    input logic rst_n,
    md5_in_if.sink    in_ch,
    md5_out_if.source out_ch
);

    md5_pkg::md5_cmd_t  cmd;
    md5_pkg::md5_stat_t stat;
    logic [1:0]         out_sel;

    md5_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .byte_count      (in_ch.byte_count),
        .last_of_message (in_ch.last_of_message),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_sel         (out_sel),
        .cmd             (cmd),
        .stat            (stat)
    );

    md5_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .data_word       (in_ch.data_word),
        .byte_count      (in_ch.byte_count),
        .last_of_message (in_ch.last_of_message),
        .out_sel         (out_sel),
        .chain_word      (out_ch.digest_word)
    );

    assign out_ch.word_index = out_sel;
    assign out_ch.last_word = (out_sel == 2'd3);

endmodule
